@@ rtl/core/psf_circular_blur_core_assert.svh @@
// Assertion macros for the PSF circular blur core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PSF_CIRCULAR_BLUR_CORE_ASSERT_SVH
`define PSF_CIRCULAR_BLUR_CORE_ASSERT_SVH

// Same-cycle implication.
`define PSFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psfb: same-cycle check failed");

// Next-cycle implication.
`define PSFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psfb: next-cycle check failed");

`endif

@@ rtl/core/psfb_pkg.sv @@
// Shared types and constants for the PSF circular blur core.
// No dependencies.
package psfb_pkg;

  localparam int REQ_W      = 2;
  localparam int COORD_W    = 6;
  localparam int DATA_W     = 16;
  localparam int DIMCFG_W   = 7;
  localparam int PSF_SIZE_W = 4;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // product 17x16 signed, up to 225 taps summed
  localparam int PROD_W = 33;
  localparam int ACC_W  = 41;
  localparam int WS_W   = 24;
  localparam int Q_W    = 16;
  localparam int DC_W   = 4;

  localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLS = 2'd1;
  localparam logic [1:0] REG_PSF_SIZE   = 2'd2;

  localparam logic [DIMCFG_W-1:0]   ROWS_RST     = 7'd64;
  localparam logic [DIMCFG_W-1:0]   COLS_RST     = 7'd64;
  localparam logic [PSF_SIZE_W-1:0] PSF_SIZE_RST = 4'd1;

  typedef struct packed {
    logic clr_step;
    logic load_psf;
    logic load_img;
    logic start;
    logic mod_step;
    logic tap_init;
    logic tap_issue;
    logic div_init;
    logic div_step;
    logic res_load;
  } psfb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic k_zero;
    logic tap_last;
    logic pipe_busy;
    logic div_last;
    logic out_free;
  } psfb_sts_t;

endpackage

@@ rtl/core/psf_circular_blur_core.sv @@
// PSF circular blur core: one weight/pixel load or one output pixel per beat.
// Loads take one input beat each and are accepted back to back. A compute
// request stalls the input until its result beat is presented; the wait
// covers the wrap search, the tap sweep, the divide and a wait while the
// previous result still sits in the output register. K is the effective
// PSF size and n = max((row+K/2)/R, (col+K/2)/C) is the number of wrap
// subtractions. The single multiply-accumulate walks one tap per cycle and a
// 16-step divider forms the normalized value. After reset all
// MAX_PSF_DIM*MAX_PSF_DIM weight RAM entries are cleared with input stalled.
// Depends on psfb_pkg, psfb_ctrl, psfb_dp, psfb_ram.
module psf_circular_blur_core
  import psfb_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 64,
  parameter int MAX_PSF_DIM   = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [COORD_W-1:0]       row_i,
  input  logic [COORD_W-1:0]       col_i,
  input  logic [DATA_W-1:0]        psf_weight_i,
  input  logic signed [DATA_W-1:0] pixel_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [COORD_W-1:0]       out_row_o,
  output logic [COORD_W-1:0]       out_col_o,
  output logic signed [DATA_W-1:0] blurred_value_o,
  output logic                     zero_weight_sum_o
);

  logic [DIMCFG_W-1:0]   cfg_rows_q, cfg_cols_q;
  logic [PSF_SIZE_W-1:0] cfg_psf_size_q;
  logic [1:0]            reg_idx;
  logic                  apb_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign apb_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q     <= ROWS_RST;
      cfg_cols_q     <= COLS_RST;
      cfg_psf_size_q <= PSF_SIZE_RST;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_IMAGE_ROWS: cfg_rows_q     <= pwdata[DIMCFG_W-1:0];
        REG_IMAGE_COLS: cfg_cols_q     <= pwdata[DIMCFG_W-1:0];
        REG_PSF_SIZE:   cfg_psf_size_q <= pwdata[PSF_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_ROWS: prdata = APB_DW'(cfg_rows_q);
      REG_IMAGE_COLS: prdata = APB_DW'(cfg_cols_q);
      REG_PSF_SIZE:   prdata = APB_DW'(cfg_psf_size_q);
      default:        prdata = '0;
    endcase
  end

  psfb_cmd_t cmd;
  psfb_sts_t sts;

  psfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psfb_dp #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .MAX_PSF_DIM   (MAX_PSF_DIM)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_rows_i        (cfg_rows_q),
    .cfg_cols_i        (cfg_cols_q),
    .cfg_psf_size_i    (cfg_psf_size_q),
    .row_i             (row_i),
    .col_i             (col_i),
    .psf_weight_i      (psf_weight_i),
    .pixel_value_i     (pixel_value_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_row_o         (out_row_o),
    .out_col_o         (out_col_o),
    .blurred_value_o   (blurred_value_o),
    .zero_weight_sum_o (zero_weight_sum_o)
  );

  logic compute_beat;

  assign compute_beat = in_valid_i && !in_stall_o && (req_type_i == REQ_COMPUTE);

`include "psf_circular_blur_core_assert.svh"

  `PSFB_ASSERT_IMP(a_zero_sum_value, out_valid_o && zero_weight_sum_o, blurred_value_o == '0)
  `PSFB_ASSERT_IMP(a_pipe_stalls_in, sts.pipe_busy, in_stall_o)
  `PSFB_ASSERT_NXT(a_compute_stalls, compute_beat, in_stall_o)

endmodule

@@ rtl/core/psfb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/psfb_ctrl.sv @@
// Sequencer of the PSF blur core: clearing pass, loads, wrap search,
// tap sweep, divide and result hand-off. Depends on psfb_pkg.
module psfb_ctrl
  import psfb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             in_stall_o,
  input  psfb_sts_t        sts_i,
  output psfb_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_TAP,
    ST_DRAIN,
    ST_DIV,
    ST_RES
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_WEIGHT: cmd_o.load_psf = 1'b1;
            REQ_PIXEL:  cmd_o.load_img = 1'b1;
            REQ_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_MOD;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.tap_init = 1'b1;
          state_d        = sts_i.k_zero ? ST_DRAIN : ST_TAP;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      ST_TAP: begin
        cmd_o.tap_issue = 1'b1;
        if (sts_i.tap_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ rtl/core/psfb_dp.sv @@
// Datapath of the PSF blur core: weight and image RAMs, wrap counters,
// multiply-accumulate pipe, 16-step divider and output register.
// Depends on psfb_pkg and psfb_ram.
module psfb_dp
  import psfb_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 64,
  parameter int MAX_PSF_DIM   = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DIMCFG_W-1:0]      cfg_rows_i,
  input  logic [DIMCFG_W-1:0]      cfg_cols_i,
  input  logic [PSF_SIZE_W-1:0]    cfg_psf_size_i,
  input  logic [COORD_W-1:0]       row_i,
  input  logic [COORD_W-1:0]       col_i,
  input  logic [DATA_W-1:0]        psf_weight_i,
  input  logic signed [DATA_W-1:0] pixel_value_i,
  input  logic                     out_stall_i,
  input  psfb_cmd_t                cmd_i,
  output psfb_sts_t                sts_o,
  output logic                     out_valid_o,
  output logic [COORD_W-1:0]       out_row_o,
  output logic [COORD_W-1:0]       out_col_o,
  output logic signed [DATA_W-1:0] blurred_value_o,
  output logic                     zero_weight_sum_o
);

  localparam int PSF_DEPTH = MAX_PSF_DIM * MAX_PSF_DIM;
  localparam int IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int PA_W      = (PSF_DEPTH > 1) ? $clog2(PSF_DEPTH) : 1;
  localparam int IA_W      = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int DIM_W     = $clog2(MAX_IMAGE_DIM + 1);
  localparam int MV_W      = (DIM_W > 7) ? DIM_W : 7;

  // effective geometry
  logic [MV_W-1:0]       dim_r, dim_c;
  logic [PSF_SIZE_W-1:0] k_eff, k_half;

  always_comb begin
    if (cfg_rows_i == '0) begin
      dim_r = MV_W'(1);
    end else if (32'(cfg_rows_i) > 32'(MAX_IMAGE_DIM)) begin
      dim_r = MV_W'(MAX_IMAGE_DIM);
    end else begin
      dim_r = MV_W'(cfg_rows_i);
    end
    if (cfg_cols_i == '0) begin
      dim_c = MV_W'(1);
    end else if (32'(cfg_cols_i) > 32'(MAX_IMAGE_DIM)) begin
      dim_c = MV_W'(MAX_IMAGE_DIM);
    end else begin
      dim_c = MV_W'(cfg_cols_i);
    end
    if (32'(cfg_psf_size_i) > 32'(MAX_PSF_DIM)) begin
      k_eff = PSF_SIZE_W'(MAX_PSF_DIM);
    end else begin
      k_eff = cfg_psf_size_i;
    end
    k_half = k_eff >> 1;
  end

  // weight RAM with clearing pass
  logic [PA_W-1:0]   clr_cnt_q;
  logic              psf_we;
  logic [PA_W-1:0]   psf_waddr, psf_raddr;
  logic [DATA_W-1:0] psf_wdata, psf_rdata;

  always_comb begin
    psf_we    = cmd_i.clr_step ||
                (cmd_i.load_psf && (32'(row_i) < MAX_PSF_DIM) && (32'(col_i) < MAX_PSF_DIM));
    psf_waddr = cmd_i.clr_step ? clr_cnt_q
                               : PA_W'(32'(row_i) * MAX_PSF_DIM + 32'(col_i));
    psf_wdata = cmd_i.clr_step ? '0 : psf_weight_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + PA_W'(1);
    end
  end

  psfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PSF_DEPTH),
    .AW    (PA_W)
  ) u_psf_ram (
    .clk_i   (clk_i),
    .we_i    (psf_we),
    .waddr_i (psf_waddr),
    .wdata_i (psf_wdata),
    .raddr_i (psf_raddr),
    .rdata_o (psf_rdata)
  );

  // image RAM
  logic              img_we;
  logic [IA_W-1:0]   img_waddr, img_raddr;
  logic [DATA_W-1:0] img_rdata;

  assign img_we    = cmd_i.load_img &&
                     (32'(row_i) < MAX_IMAGE_DIM) && (32'(col_i) < MAX_IMAGE_DIM);
  assign img_waddr = IA_W'(32'(row_i) * MAX_IMAGE_DIM + 32'(col_i));

  psfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMG_DEPTH),
    .AW    (IA_W)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i ($unsigned(pixel_value_i)),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  // wrap search and tap walk; vr_q doubles as the source row
  logic [MV_W-1:0]       vr_q, vc_q, sx_q;
  logic [PSF_SIZE_W-1:0] i_q, j_q;
  logic [PA_W-1:0]       base_q;
  logic [COORD_W-1:0]    req_row_q, req_col_q;
  logic                  col_last;

  assign col_last  = (j_q == k_eff - PSF_SIZE_W'(1));
  assign psf_raddr = PA_W'(32'(base_q) + 32'(j_q));
  assign img_raddr = IA_W'(32'(vr_q) * MAX_IMAGE_DIM + 32'(sx_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vr_q      <= MV_W'(row_i) + MV_W'(k_half);
      vc_q      <= MV_W'(col_i) + MV_W'(k_half);
      req_row_q <= row_i;
      req_col_q <= col_i;
    end else if (cmd_i.mod_step) begin
      if (vr_q >= dim_r) vr_q <= vr_q - dim_r;
      if (vc_q >= dim_c) vc_q <= vc_q - dim_c;
    end else if (cmd_i.tap_init) begin
      sx_q   <= vc_q;
      i_q    <= '0;
      j_q    <= '0;
      base_q <= '0;
    end else if (cmd_i.tap_issue) begin
      if (col_last) begin
        j_q    <= '0;
        sx_q   <= vc_q;
        i_q    <= i_q + PSF_SIZE_W'(1);
        base_q <= PA_W'(32'(base_q) + MAX_PSF_DIM);
        vr_q   <= (vr_q == '0) ? dim_r - MV_W'(1) : vr_q - MV_W'(1);
      end else begin
        j_q  <= j_q + PSF_SIZE_W'(1);
        sx_q <= (sx_q == '0) ? dim_c - MV_W'(1) : sx_q - MV_W'(1);
      end
    end
  end

  // multiply-accumulate pipe
  logic                    v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0]       w_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [WS_W-1:0]         wsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, psf_rdata}) * $signed(img_rdata);
    w_q    <= psf_rdata;
    if (cmd_i.start) begin
      acc_q  <= '0;
      wsum_q <= '0;
    end else if (v2_q) begin
      acc_q  <= acc_q + ACC_W'(prod_q);
      wsum_q <= wsum_q + WS_W'(w_q);
    end
  end

  // restoring divide on magnitudes, quotient below 2^Q_W
  logic [ACC_W-1:0] rem_q, dv_q, acc_mag;
  logic [Q_W-1:0]   quo_q;
  logic [DC_W-1:0]  div_cnt_q;
  logic             neg_q, zero_q;

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'($unsigned(-acc_q)) : ACC_W'($unsigned(acc_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q     <= acc_mag;
      dv_q      <= ACC_W'(wsum_q) << (Q_W - 1);
      quo_q     <= '0;
      div_cnt_q <= '0;
      neg_q     <= acc_q[ACC_W-1];
      zero_q    <= (wsum_q == '0);
    end else if (cmd_i.div_step) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        quo_q <= {quo_q[Q_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[Q_W-2:0], 1'b0};
      end
      dv_q      <= dv_q >> 1;
      div_cnt_q <= div_cnt_q + DC_W'(1);
    end
  end

  // signed result with saturation
  logic signed [Q_W:0]      quo_s, res_s;
  logic signed [DATA_W-1:0] res_val;

  always_comb begin
    quo_s = $signed({1'b0, quo_q});
    res_s = neg_q ? -quo_s : quo_s;
    if (res_s[Q_W] != res_s[Q_W-1]) begin
      res_val = res_s[Q_W] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                           : $signed({1'b0, {(DATA_W-1){1'b1}}});
    end else begin
      res_val = res_s[DATA_W-1:0];
    end
  end

  // output register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_row_o         <= req_row_q;
      out_col_o         <= req_col_q;
      blurred_value_o   <= zero_q ? '0 : res_val;
      zero_weight_sum_o <= zero_q;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    sts_o.clr_last  = (clr_cnt_q == PA_W'(PSF_DEPTH - 1));
    sts_o.mod_done  = (vr_q < dim_r) && (vc_q < dim_c);
    sts_o.k_zero    = (k_eff == '0);
    sts_o.tap_last  = col_last && (i_q == k_eff - PSF_SIZE_W'(1));
    sts_o.pipe_busy = v1_q || v2_q;
    sts_o.div_last  = (div_cnt_q == DC_W'(Q_W - 1));
    sts_o.out_free  = !out_vld_q || !out_stall_i;
  end

endmodule

@@ tb/psf_circular_blur_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for psf_circular_blur_core: loads PSF weights and pixels, requests
// output pixels and checks each against a built-in circular convolution predictor.
// Depends on psfb_pkg and psf_circular_blur_core.
module psf_circular_blur_core_tb;
  import psfb_pkg::*;

  localparam int IMG_DIM        = 64;
  localparam int PSF_DIM        = 15;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  value;
    logic               zflag;
  } blur_out_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i = REQ_WEIGHT;
  logic [COORD_W-1:0]       row_i = '0;
  logic [COORD_W-1:0]       col_i = '0;
  logic [DATA_W-1:0]        psf_weight_i = '0;
  logic signed [DATA_W-1:0] pixel_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [COORD_W-1:0]       out_row_o;
  logic [COORD_W-1:0]       out_col_o;
  logic signed [DATA_W-1:0] blurred_value_o;
  logic                     zero_weight_sum_o;

  // predictor state
  logic [DATA_W-1:0]        psf_w   [PSF_DIM*PSF_DIM];
  logic signed [DATA_W-1:0] img_px  [IMG_DIM*IMG_DIM];
  bit                       img_set [IMG_DIM*IMG_DIM];
  logic [DIMCFG_W-1:0]      cfg_rows = ROWS_RST;
  logic [DIMCFG_W-1:0]      cfg_cols = COLS_RST;
  logic [PSF_SIZE_W-1:0]    cfg_ksz  = PSF_SIZE_RST;

  blur_out_t pending_px [$];
  blur_out_t want;
  int        mismatch_cnt = 0;
  int        quiet_cycles = 0;
  bit        gaps_on = 1'b1;
  bit        hold_out = 1'b0;

  psf_circular_blur_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .req_type_i, .row_i, .col_i, .psf_weight_i,
    .pixel_value_i, .out_valid_o, .out_stall_i, .out_row_o, .out_col_o,
    .blurred_value_o, .zero_weight_sum_o
  );

  always #10 clk_i = ~clk_i;

  initial begin
    foreach (psf_w[i]) psf_w[i] = '0;
    foreach (img_px[i]) begin
      img_px[i]  = '0;
      img_set[i] = 1'b0;
    end
  end

  function automatic int eff_dim(input logic [DIMCFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > IMG_DIM) return IMG_DIM;
    return int'(v);
  endfunction

  function automatic int wrap_pos(input int t, input int n);
    int r;
    r = t % n;
    if (r < 0) r += n;
    return r;
  endfunction

  function automatic blur_out_t blur_pixel(input logic [COORD_W-1:0] row,
                                           input logic [COORD_W-1:0] col);
    blur_out_t r;
    int nr, nc, k, h, y, x, i, j, pos;
    longint acc, wsum, q;
    nr = eff_dim(cfg_rows);
    nc = eff_dim(cfg_cols);
    k  = int'(cfg_ksz);
    h  = k / 2;
    y  = int'(row) % nr;
    x  = int'(col) % nc;
    acc  = 0;
    wsum = 0;
    for (i = 0; i < k; i++) begin
      for (j = 0; j < k; j++) begin
        pos  = wrap_pos(y - i + h, nr) * IMG_DIM + wrap_pos(x - j + h, nc);
        wsum += longint'(psf_w[i*PSF_DIM+j]);
        acc  += longint'(psf_w[i*PSF_DIM+j]) * longint'(img_px[pos]);
      end
    end
    r.row = row;
    r.col = col;
    if (wsum == 0) begin
      r.value = '0;
      r.zflag = 1'b1;
    end else begin
      q = acc / wsum;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.value = q[DATA_W-1:0];
      r.zflag = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hffff;
      2, 3: return DATA_W'($urandom_range(0, 3));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIMCFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIMCFG_W'($urandom_range(65, 127));
      2, 3: return DIMCFG_W'($urandom_range(33, 64));
      default: return DIMCFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(input logic [DIMCFG_W-1:0] dim);
    if ($urandom_range(0, 3) == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, eff_dim(dim) - 1));
  endfunction

  // one input beat; valid is left high so back-to-back beats need no drop
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic [DATA_W-1:0] w,
                           input logic [DATA_W-1:0] pix);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    row_i         <= row;
    col_i         <= col;
    psf_weight_i  <= w;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (req)
      REQ_WEIGHT: if (row < PSF_DIM && col < PSF_DIM) psf_w[row*PSF_DIM+col] = w;
      REQ_PIXEL: begin
        img_px[{row, col}]  = pix;
        img_set[{row, col}] = 1'b1;
      end
      REQ_COMPUTE: pending_px.push_back(blur_pixel(row, col));
      default: ;
    endcase
  endtask

  task automatic quiet_input();
    in_valid_i <= 1'b0;
  endtask

  // write any pixel of the request's window that has never been loaded, then send the request
  task automatic send_compute(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    int nr, nc, k, h, y, x, i, j, pos;
    nr = eff_dim(cfg_rows);
    nc = eff_dim(cfg_cols);
    k  = int'(cfg_ksz);
    h  = k / 2;
    y  = int'(row) % nr;
    x  = int'(col) % nc;
    for (i = 0; i < k; i++) begin
      for (j = 0; j < k; j++) begin
        pos = wrap_pos(y - i + h, nr) * IMG_DIM + wrap_pos(x - j + h, nc);
        if (!img_set[pos])
          send_beat(REQ_PIXEL, COORD_W'(pos / IMG_DIM), COORD_W'(pos % IMG_DIM),
                    DATA_W'($urandom), rand_pixel());
      end
    end
    send_beat(REQ_COMPUTE, row, col, DATA_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic load_psf(input bit all_zero);
    int i, j;
    for (i = 0; i < cfg_ksz; i++) begin
      for (j = 0; j < cfg_ksz; j++) begin
        send_beat(REQ_WEIGHT, COORD_W'(i), COORD_W'(j),
                  all_zero ? 16'h0000 : rand_weight(), DATA_W'($urandom));
      end
    end
  endtask

  task automatic random_beats(input int count);
    int n, s;
    for (n = 0; n < count; n++) begin
      s = $urandom_range(0, 99);
      if (s < 50) begin
        send_compute(rand_coord(cfg_rows), rand_coord(cfg_cols));
      end else if (s < 78) begin
        send_beat(REQ_PIXEL, COORD_W'($urandom_range(0, eff_dim(cfg_rows) - 1)),
                  COORD_W'($urandom_range(0, eff_dim(cfg_cols) - 1)),
                  DATA_W'($urandom), rand_pixel());
      end else if (s < 88) begin
        send_beat(REQ_WEIGHT, COORD_W'($urandom_range(0, 17)),
                  COORD_W'($urandom_range(0, 17)), rand_weight(), DATA_W'($urandom));
      end else if (s < 95) begin
        send_beat(REQ_PIXEL, COORD_W'($urandom), COORD_W'($urandom), DATA_W'($urandom),
                  rand_pixel());
      end else begin
        send_beat(REQ_UNUSED, COORD_W'($urandom), COORD_W'($urandom), DATA_W'($urandom),
                  DATA_W'($urandom));
      end
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DIMCFG_W-1:0] val);
    logic [APB_DW-1:0] mask, word;
    mask = (idx == REG_PSF_SIZE) ? 32'h0000_000f : 32'h0000_007f;
    word = (APB_DW'($urandom) & ~mask) | (APB_DW'(val) & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_IMAGE_ROWS: cfg_rows = word[DIMCFG_W-1:0];
      REG_IMAGE_COLS: cfg_cols = word[DIMCFG_W-1:0];
      default:        cfg_ksz  = word[PSF_SIZE_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== (word & mask)) begin
      $error("prdata expected %0h got %0h", word & mask, prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    quiet_input();
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic setup(input logic [DIMCFG_W-1:0] rows, input logic [DIMCFG_W-1:0] cols,
                       input logic [PSF_SIZE_W-1:0] ksz);
    settle();
    reg_write(REG_IMAGE_ROWS, rows);
    reg_write(REG_IMAGE_COLS, cols);
    reg_write(REG_PSF_SIZE, ksz);
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    setup(7'd64, 7'd64, 4'd1);
    send_beat(REQ_PIXEL, 6'd0, 6'd0, 16'h0000, 16'h7fff);
    send_compute(6'd0, 6'd0);                    // weights still all zero
    send_beat(REQ_UNUSED, 6'd5, 6'd5, 16'hffff, 16'hffff);
    send_beat(REQ_WEIGHT, 6'd0, 6'd0, 16'hffff, 16'h0000);
    send_compute(6'd0, 6'd0);
    send_beat(REQ_PIXEL, 6'd63, 6'd63, 16'h0000, 16'h8000);
    send_compute(6'd63, 6'd63);
    send_beat(REQ_WEIGHT, 6'd15, 6'd0, 16'd5, 16'h0000);   // outside weight store
    send_beat(REQ_WEIGHT, 6'd0, 6'd15, 16'd7, 16'h0000);
    send_beat(REQ_WEIGHT, 6'd63, 6'd63, 16'd9, 16'h0000);
    send_compute(6'd0, 6'd0);
    setup(7'd64, 7'd64, 4'd0);                   // empty PSF
    send_compute(6'd10, 6'd20);
    setup(7'd127, 7'd0, 4'd3);                   // rows clamp high, cols clamp to one
    load_psf(1'b0);
    send_beat(REQ_WEIGHT, 6'd1, 6'd1, 16'hffff, 16'h0000);
    send_compute(6'd63, 6'd63);
    send_compute(6'd0, 6'd0);
    setup(7'd5, 7'd5, 4'd4);                     // even PSF, requests beyond image
    load_psf(1'b0);
    send_compute(6'd63, 6'd0);
    send_compute(6'd2, 6'd2);
    setup(7'd1, 7'd1, 4'd15);                    // PSF far larger than image
    send_compute(6'd7, 6'd7);
    send_compute(6'd63, 6'd63);
  endtask

  task automatic test_random_phases();
    int p;
    logic [DIMCFG_W-1:0] rows, cols;
    logic [PSF_SIZE_W-1:0] ksz;
    for (p = 0; p < 5; p++) begin
      rows = pick_dim();
      cols = pick_dim();
      if (eff_dim(rows) > 16 || eff_dim(cols) > 16) begin
        ksz = PSF_SIZE_W'(2 * $urandom_range(0, 1) + 1);
      end else begin
        case ($urandom_range(0, 9))
          0: ksz = '0;
          1: ksz = PSF_SIZE_W'(2 * $urandom_range(1, 7));
          default: ksz = PSF_SIZE_W'(2 * $urandom_range(0, 7) + 1);
        endcase
      end
      gaps_on = (p % 3 != 2);
      setup(rows, cols, ksz);
      load_psf($urandom_range(0, 7) == 0);
      random_beats(40);
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    setup(7'd8, 7'd8, 4'd3);
    load_psf(1'b0);
    hold_out = 1'b1;
    random_beats(30);
    quiet_input();
    while (pending_px.size() != 0) @(posedge clk_i);
    gaps_on = 1'b1;
    random_beats(40);
  endtask

  task automatic test_calm();
    gaps_on = 1'b0;
    setup(7'd16, 7'd16, 4'd5);
    load_psf(1'b0);
    random_beats(60);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    test_calm();
    settle();
    if (mismatch_cnt == 0 && pending_px.size() == 0) begin
      $display("psf_circular_blur_core: match");
    end else begin
      $display("psf_circular_blur_core: mismatch");
    end
    $finish;
  end

  // result side: long hold on request, else random stall bursts when gaps are enabled
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
        out_stall_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        $error("result beat with nothing pending: row %0d col %0d", out_row_o, out_col_o);
        mismatch_cnt++;
      end else begin
        want = pending_px.pop_front();
        if (out_row_o !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, out_row_o);
          mismatch_cnt++;
        end
        if (out_col_o !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, out_col_o);
          mismatch_cnt++;
        end
        if (blurred_value_o !== want.value) begin
          $error("blurred_value expected %0d got %0d", $signed(want.value), blurred_value_o);
          mismatch_cnt++;
        end
        if (zero_weight_sum_o !== want.zflag) begin
          $error("zero_weight_sum expected %0d got %0d", want.zflag, zero_weight_sum_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("psf_circular_blur_core: mismatch");
        $finish;
      end
    end
  end

endmodule
